@@ src/byte_lane_memory_fill_move_engine_unit_macros.svh @@
// Assertion macros used by the byte-lane memory engine sequencer.
`ifndef BYTE_LANE_MEMORY_FILL_MOVE_ENGINE_UNIT_MACROS_SVH
`define BYTE_LANE_MEMORY_FILL_MOVE_ENGINE_UNIT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define BLMF_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define BLMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/blmf_pkg.sv @@
// Types, request codes and lane helpers for the byte-lane memory engine.
package blmf_pkg;

    // Byte pointer width: covers any start plus length that passes the range checks.
    localparam int PTR_W  = 10;
    // Word cursor width for fill walks.
    localparam int WCUR_W = 8;

    localparam logic [2:0] REQ_RD_BYTE = 3'd0;
    localparam logic [2:0] REQ_RD_HALF = 3'd1;
    localparam logic [2:0] REQ_RD_WORD = 3'd2;
    localparam logic [2:0] REQ_WR_BYTE = 3'd3;
    localparam logic [2:0] REQ_WR_HALF = 3'd4;
    localparam logic [2:0] REQ_WR_WORD = 3'd5;
    localparam logic [2:0] REQ_FILL    = 3'd6;
    localparam logic [2:0] REQ_MOVE    = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  addr;
        logic [31:0] wdata;
        logic [8:0]  src_addr;
        logic [9:0]  length;
    } blmf_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] rdata;
        logic        ok;
    } blmf_res_t;

    // Replaces the enabled byte lanes of a word.
    function automatic logic [31:0] merge_lanes(input logic [31:0] old_word,
                                                input logic [31:0] new_word,
                                                input logic [3:0]  lane_en);
        logic [31:0] merged;
        merged = old_word;
        for (int k = 0; k < 4; k++) begin
            if (lane_en[k]) begin
                merged[k*8 +: 8] = new_word[k*8 +: 8];
            end
        end
        return merged;
    endfunction

endpackage

@@ src/byte_lane_memory_fill_move_engine_unit.sv @@
// Top level of the byte-lane memory engine: stream ports and the result register.
//
// Requests arrive on the s_ channel. s_tuser carries the request type and s_tdata the
// address, write data, source address and length. Each request yields exactly one
// result on the m_ channel: m_tdata is the read value (zero for writes, fills, moves
// and rejected requests) and m_tuser is the ok flag. Requests are served one at a time.
// Byte, halfword and word reads and writes first read the word from the RAM and then
// merge, write back and report into the result register.
// A fill reads and rewrites one word per cycle after the first read. A move copies one
// byte at a time (read the source word, then read, merge and write the destination
// word); the pace of both walks is set by the single registered RAM read port.
// A rejected request takes the single-access path and leaves the memory unchanged.
// After reset the block sweeps the whole store to zero, one word per cycle, with s_tready
// low until the sweep ends. A finished result waits in the output register; a new
// request is accepted meanwhile, and a stalled receiver only holds the engine once its
// next result is ready.
module byte_lane_memory_fill_move_engine_unit
    import blmf_pkg::*;
    #(
        parameter int MEM_BYTES = 512
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_tvalid,
        output logic        s_tready,
        input  logic [63:0] s_tdata,   // addr[8:0], wdata[40:9], src_addr[49:41],
                                       // length[59:50], zero fill[63:60]
        input  logic [2:0]  s_tuser,   // req_type[2:0]
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [31:0] m_tdata,   // rdata[31:0]
        output logic        m_tuser    // ok[0]
    );

    blmf_req_t   req;
    blmf_res_t   eng_res;
    logic        out_free;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    // Unpack the request fields from the stream payload.
    always_comb begin
        req.req_type = s_tuser;
        req.addr     = s_tdata[8:0];
        req.wdata    = s_tdata[40:9];
        req.src_addr = s_tdata[49:41];
        req.length   = s_tdata[59:50];
    end

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    blmf_engine #(
        .MEM_BYTES (MEM_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .out_free  (out_free),
        .res       (eng_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (eng_res.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = eng_res.rdata;
            m_tuser_next  = eng_res.ok;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ src/blmf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module blmf_ram
    #(
        parameter int WIDTH  = 32,
        parameter int DEPTH  = 128,
        localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              aclk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/blmf_engine.sv @@
// Request sequencer: range checks, read-modify-write, fill and move walks over the word RAM.
`include "byte_lane_memory_fill_move_engine_unit_macros.svh"

module blmf_engine
    import blmf_pkg::*;
    #(
        parameter int MEM_BYTES = 512
    )
    (
        input  logic      aclk,
        input  logic      aresetn,
        input  blmf_req_t req,
        input  logic      req_valid,
        output logic      req_ready,
        input  logic      out_free,
        output blmf_res_t res
    );

    localparam int WORD_COUNT = (MEM_BYTES + 3) / 4;
    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [31:0] LIM_BYTE = 32'(MEM_BYTES);
    localparam logic [31:0] LIM_HALF = 32'(MEM_BYTES / 2);
    localparam logic [31:0] LIM_WORD = 32'(MEM_BYTES / 4);
    localparam logic [AW-1:0] LAST_IDX = AW'(WORD_COUNT - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SINGLE = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_MSRC   = 3'd4;
    localparam logic [2:0] ST_MDST   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [2:0]        type_reg, type_next;
    logic [8:0]        addr_reg, addr_next;
    logic [31:0]       wdata_reg, wdata_next;
    logic              ok_reg, ok_next;
    logic [AW-1:0]     widx_reg, widx_next;
    logic [10:0]       fend_reg, fend_next;
    logic [WCUR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0]  sp_reg, sp_next;
    logic [PTR_W-1:0]  dp_reg, dp_next;
    logic [9:0]        cnt_reg, cnt_next;
    logic              back_reg, back_next;
    logic [7:0]        sbyte_reg, sbyte_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [31:0]       fwd_data_reg, fwd_data_next;
    logic [31:0]       res_rdata_reg, res_rdata_next;
    logic              res_ok_reg, res_ok_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       rd_eff;

    logic              acc;
    logic [10:0]       sum_dst;
    logic [10:0]       sum_src;
    logic              fill_ok;
    logic              move_ok;
    logic              ok_in;
    logic [AW-1:0]     widx_in;
    logic              back_in;
    logic [PTR_W-1:0]  first_src;
    logic [PTR_W-1:0]  first_dst;

    logic              finish;
    logic [31:0]       fin_rdata;
    logic              fin_ok;
    logic [3:0]        fill_en;

    blmf_ram #(
        .WIDTH (32),
        .DEPTH (WORD_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A read issued in the same cycle as a write to the same word sees the new value.
    assign rd_eff    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign req_ready = (state_reg == ST_IDLE);
    assign acc       = req_valid && req_ready;

    // Range checks on the incoming request.
    assign sum_dst = {2'b00, req.addr} + {1'b0, req.length};
    assign sum_src = {2'b00, req.src_addr} + {1'b0, req.length};
    assign fill_ok = (req.length != 10'd0) && (32'(sum_dst) <= LIM_BYTE);
    assign move_ok = fill_ok && (32'(sum_src) <= LIM_BYTE) && (req.addr != req.src_addr);
    assign back_in = !(req.addr < req.src_addr);
    assign first_src = back_in ? PTR_W'(sum_src - 11'd1) : PTR_W'(req.src_addr);
    assign first_dst = back_in ? PTR_W'(sum_dst - 11'd1) : PTR_W'(req.addr);

    always_comb begin
        unique case (req.req_type) inside
            REQ_RD_BYTE, REQ_WR_BYTE: begin
                ok_in   = 32'(req.addr) < LIM_BYTE;
                widx_in = AW'(req.addr >> 2);
            end
            REQ_RD_HALF, REQ_WR_HALF: begin
                ok_in   = 32'(req.addr) < LIM_HALF;
                widx_in = AW'(req.addr >> 1);
            end
            REQ_RD_WORD, REQ_WR_WORD: begin
                ok_in   = 32'(req.addr) < LIM_WORD;
                widx_in = AW'(req.addr);
            end
            REQ_FILL: begin
                ok_in   = fill_ok;
                widx_in = AW'(req.addr >> 2);
            end
            REQ_MOVE: begin
                ok_in   = move_ok;
                widx_in = AW'(first_src >> 2);
            end
            default: begin
                ok_in   = 1'b0;
                widx_in = '0;
            end
        endcase
    end

    // Lanes of the current fill word that fall inside the range.
    always_comb begin
        logic [10:0] lane_byte;
        lane_byte = '0;
        for (int k = 0; k < 4; k++) begin
            lane_byte  = {1'b0, cur_reg, 2'(k)};
            fill_en[k] = (lane_byte >= {2'b00, addr_reg}) && (lane_byte < fend_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        type_next      = type_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        ok_next        = ok_reg;
        widx_next      = widx_reg;
        fend_next      = fend_reg;
        cur_next       = cur_reg;
        sp_next        = sp_reg;
        dp_next        = dp_reg;
        cnt_next       = cnt_reg;
        back_next      = back_reg;
        sbyte_next     = sbyte_reg;
        res_rdata_next = res_rdata_reg;
        res_ok_next    = res_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        finish         = 1'b0;
        fin_rdata      = '0;
        fin_ok         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    type_next  = req.req_type;
                    addr_next  = req.addr;
                    wdata_next = req.wdata;
                    ok_next    = ok_in;
                    widx_next  = widx_in;
                    fend_next  = sum_dst;
                    cur_next   = WCUR_W'(req.addr >> 2);
                    sp_next    = first_src;
                    dp_next    = first_dst;
                    cnt_next   = req.length;
                    back_next  = back_in;
                    ram_re     = 1'b1;
                    ram_raddr  = widx_in;
                    if (ok_in && req.req_type == REQ_FILL) begin
                        state_next = ST_FILL;
                    end else if (ok_in && req.req_type == REQ_MOVE) begin
                        state_next = ST_MSRC;
                    end else begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_SINGLE: begin
                finish    = 1'b1;
                fin_ok    = ok_reg;
                ram_waddr = widx_reg;
                if (ok_reg) begin
                    unique case (type_reg)
                        REQ_RD_BYTE: fin_rdata = {24'd0, rd_eff[{addr_reg[1:0], 3'b000} +: 8]};
                        REQ_RD_HALF: fin_rdata = {16'd0, rd_eff[{addr_reg[0], 4'b0000} +: 16]};
                        REQ_RD_WORD: fin_rdata = rd_eff;
                        REQ_WR_BYTE: begin
                            ram_we    = 1'b1;
                            ram_wdata = merge_lanes(rd_eff, {4{wdata_reg[7:0]}},
                                                    4'b0001 << addr_reg[1:0]);
                        end
                        REQ_WR_HALF: begin
                            ram_we    = 1'b1;
                            ram_wdata = merge_lanes(rd_eff, {2{wdata_reg[15:0]}},
                                                    addr_reg[0] ? 4'b1100 : 4'b0011);
                        end
                        REQ_WR_WORD: begin
                            ram_we    = 1'b1;
                            ram_wdata = wdata_reg;
                        end
                        default: fin_rdata = '0;
                    endcase
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cur_reg);
                ram_wdata = merge_lanes(rd_eff, {4{wdata_reg[7:0]}}, fill_en);
                if (({1'b0, cur_reg, 2'b11} + 11'd1) >= fend_reg) begin
                    finish = 1'b1;
                    fin_ok = 1'b1;
                end else begin
                    cur_next  = cur_reg + WCUR_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = AW'(cur_reg + WCUR_W'(1));
                end
            end
            ST_MSRC: begin
                sbyte_next = rd_eff[{sp_reg[1:0], 3'b000} +: 8];
                ram_re     = 1'b1;
                ram_raddr  = AW'(dp_reg >> 2);
                state_next = ST_MDST;
            end
            ST_MDST: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(dp_reg >> 2);
                ram_wdata = merge_lanes(rd_eff, {4{sbyte_reg}}, 4'b0001 << dp_reg[1:0]);
                if (cnt_reg == 10'd1) begin
                    finish = 1'b1;
                    fin_ok = 1'b1;
                end else begin
                    sp_next    = back_reg ? sp_reg - PTR_W'(1) : sp_reg + PTR_W'(1);
                    dp_next    = back_reg ? dp_reg - PTR_W'(1) : dp_reg + PTR_W'(1);
                    cnt_next   = cnt_reg - 10'd1;
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(sp_next >> 2);
                    state_next = ST_MSRC;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            res_rdata_next = fin_rdata;
            res_ok_next    = fin_ok;
            state_next     = out_free ? ST_IDLE : ST_DONE;
        end
    end

    assign fwd_hit_next  = ram_we && ram_re && (ram_waddr == ram_raddr);
    assign fwd_data_next = ram_wdata;

    always_comb begin
        res.valid = (finish || state_reg == ST_DONE) && out_free;
        res.rdata = (state_reg == ST_DONE) ? res_rdata_reg : fin_rdata;
        res.ok    = (state_reg == ST_DONE) ? res_ok_reg : fin_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg      <= type_next;
        addr_reg      <= addr_next;
        wdata_reg     <= wdata_next;
        ok_reg        <= ok_next;
        widx_reg      <= widx_next;
        fend_reg      <= fend_next;
        cur_reg       <= cur_next;
        sp_reg        <= sp_next;
        dp_reg        <= dp_next;
        cnt_reg       <= cnt_next;
        back_reg      <= back_next;
        sbyte_reg     <= sbyte_next;
        fwd_data_reg  <= fwd_data_next;
        res_rdata_reg <= res_rdata_next;
        res_ok_reg    <= res_ok_next;
    end

    `BLMF_ASSERT_NOW(a_res_has_room, res.valid |-> out_free, "result offered while output is full")
    `BLMF_ASSERT_NOW(a_idle_no_write, (state_reg == ST_IDLE) |-> !ram_we, "RAM written while idle")
    `BLMF_ASSERT_NEXT(a_fwd_capture, ram_we && ram_re && (ram_waddr == ram_raddr), fwd_hit_reg, "same-word read and write not forwarded")

endmodule
